### rtl/rpi_pkg.sv
package rpi_pkg;

   localparam int WORD_BITS = 32;
   localparam int FRAC_BITS = 16;

   // intermediate widths, all derived from the word width
   localparam int DIFF_BITS = WORD_BITS + 1;        // cam - origin
   localparam int PA_BITS   = 2 * WORD_BITS + 1;    // diff * normal
   localparam int PB_BITS   = 2 * WORD_BITS;        // ray * normal
   localparam int A_BITS    = 2 * WORD_BITS + 3;    // signed sum of three pa
   localparam int B_BITS    = 2 * WORD_BITS + 2;    // signed sum of three pb
   localparam int AM_BITS   = 2 * WORD_BITS + 2;    // |a|
   localparam int BM_BITS   = 2 * WORD_BITS + 1;    // |b|
   localparam int AH_BITS   = AM_BITS - WORD_BITS;  // upper slice of |a|
   localparam int N_BITS    = AM_BITS + WORD_BITS;  // |a| * |ray|
   localparam int Q_BITS    = WORD_BITS + 1;        // quotient bits kept
   localparam int H_BITS    = N_BITS - Q_BITS;      // numerator bits above quotient
   localparam int SUM_BITS  = WORD_BITS + 3;        // cam + offset before clamp

   localparam int CSR_IDX_BITS = 3;

   typedef enum logic [CSR_IDX_BITS-1:0] {
      CSR_ORIGIN_X = 3'd0,
      CSR_ORIGIN_Y = 3'd1,
      CSR_ORIGIN_Z = 3'd2,
      CSR_NORMAL_X = 3'd3,
      CSR_NORMAL_Y = 3'd4,
      CSR_NORMAL_Z = 3'd5
   } csr_index_type;

   typedef struct packed {
      logic signed [WORD_BITS-1:0] ray_x;
      logic signed [WORD_BITS-1:0] ray_y;
      logic signed [WORD_BITS-1:0] ray_z;
      logic signed [WORD_BITS-1:0] cam_x;
      logic signed [WORD_BITS-1:0] cam_y;
      logic signed [WORD_BITS-1:0] cam_z;
      logic                        ortho;
   } req_type;

   typedef struct packed {
      logic signed [WORD_BITS-1:0] hit_x;
      logic signed [WORD_BITS-1:0] hit_y;
      logic signed [WORD_BITS-1:0] hit_z;
      logic                        parallel;
   } rsp_type;

   // fields that ride along the whole pipe
   typedef struct packed {
      logic                           ortho;
      logic [2:0][WORD_BITS-1:0]      ray;
      logic [2:0][WORD_BITS-1:0]      cam;
   } carry_type;

   // sideband of one divider stage
   typedef struct packed {
      carry_type                      carry;
      logic                           parallel;
      logic [2:0]                     ovf;
      logic [BM_BITS-1:0]             div;
   } div_side_type;

   localparam logic signed [SUM_BITS-1:0] SAT_MAX =
      SUM_BITS'({1'b0, {(WORD_BITS-1){1'b1}}});
   localparam logic signed [SUM_BITS-1:0] SAT_MIN =
      -SAT_MAX - SUM_BITS'(1);

   function automatic logic [WORD_BITS-1:0] sat_word(input logic signed [SUM_BITS-1:0] v);
      logic [WORD_BITS-1:0] r;
      if (v > SAT_MAX) begin
         r = SAT_MAX[WORD_BITS-1:0];
      end else if (v < SAT_MIN) begin
         r = SAT_MIN[WORD_BITS-1:0];
      end else begin
         r = v[WORD_BITS-1:0];
      end
      return r;
   endfunction

endpackage

### rtl/ray_plane_intersection.sv
// channel   dir  handshake              payload
// req       in   req_valid/req_stall    req_data  (ray, camera, ortho)
// rsp       out  rsp_valid/rsp_stall    rsp_data  (hit point, parallel)
// csr       in   csr_wr_en              csr_index, csr_wdata
//
// one transfer per cycle on each side while rsp_stall does not hold the pipe;
// the divider is a restoring one with one quotient bit per stage
// reset is synchronous, clears the valid bits and the plane origin and sets the normal to +x
// the whole pipe holds while a result waits in the output register under stall
module ray_plane_intersection (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   output logic                                  req_stall,
   input  rpi_pkg::req_type                      req_data,
   output logic                                  rsp_valid,
   input  logic                                  rsp_stall,
   output rpi_pkg::rsp_type                      rsp_data,
   input  logic                                  csr_wr_en,
   input  logic [rpi_pkg::CSR_IDX_BITS-1:0]      csr_index,
   input  logic [rpi_pkg::WORD_BITS-1:0]         csr_wdata
);
   import rpi_pkg::*;

   // plane registers
   logic [2:0][WORD_BITS-1:0] org_ff;
   logic [2:0][WORD_BITS-1:0] nrm_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         org_ff <= '0;
         // normal resets to +x at unit length
         nrm_ff <= {{(2*WORD_BITS){1'b0}}, WORD_BITS'(1) << FRAC_BITS};
      end else if (csr_wr_en) begin
         if (csr_index == CSR_ORIGIN_X) org_ff[0] <= csr_wdata;
         if (csr_index == CSR_ORIGIN_Y) org_ff[1] <= csr_wdata;
         if (csr_index == CSR_ORIGIN_Z) org_ff[2] <= csr_wdata;
         if (csr_index == CSR_NORMAL_X) nrm_ff[0] <= csr_wdata;
         if (csr_index == CSR_NORMAL_Y) nrm_ff[1] <= csr_wdata;
         if (csr_index == CSR_NORMAL_Z) nrm_ff[2] <= csr_wdata;
      end
   end

   // the pipe moves as one: it advances whenever the output slot frees up
   logic adv;
   logic rsp_valid_ff;
   assign adv       = !rsp_valid_ff || !rsp_stall;
   assign req_stall = !adv;
   assign rsp_valid = rsp_valid_ff;

   logic [6:0] vld_ff;   // valid bits of the front stages

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (adv) begin
         vld_ff <= {vld_ff[5:0], req_valid};
      end
   end

   carry_type carry_in;
   always_comb begin
      carry_in.ortho  = req_data.ortho;
      carry_in.ray[0] = req_data.ray_x;
      carry_in.ray[1] = req_data.ray_y;
      carry_in.ray[2] = req_data.ray_z;
      carry_in.cam[0] = req_data.cam_x;
      carry_in.cam[1] = req_data.cam_y;
      carry_in.cam[2] = req_data.cam_z;
   end

   // s1: camera minus plane origin
   carry_type                          c1_ff;
   logic signed [DIFF_BITS-1:0]        diff1_ff [3];
   logic [2:0][WORD_BITS-1:0]          nrm1_ff;
   // s2: products for both dot products
   carry_type                          c2_ff;
   logic signed [PA_BITS-1:0]          pa2_ff [3];
   logic signed [PB_BITS-1:0]          pb2_ff [3];
   // s3: dot products
   carry_type                          c3_ff;
   logic signed [A_BITS-1:0]           a3_ff;
   logic signed [B_BITS-1:0]           b3_ff;
   // s4: magnitudes, parallel test
   carry_type                          c4_ff;
   logic [AM_BITS-1:0]                 am4_ff;
   logic [BM_BITS-1:0]                 bm4_ff;
   logic [2:0][WORD_BITS-1:0]          rabs4_ff;
   logic                               par4_ff;
   // s5: partial products of |a| * |ray|
   carry_type                          c5_ff;
   logic [BM_BITS-1:0]                 bm5_ff;
   logic                               par5_ff;
   logic [2*WORD_BITS-1:0]             pplo5_ff [3];
   logic [AH_BITS+WORD_BITS-1:0]       pphi5_ff [3];
   // s6: full numerators
   carry_type                          c6_ff;
   logic [BM_BITS-1:0]                 bm6_ff;
   logic                               par6_ff;
   logic [N_BITS-1:0]                  n6_ff [3];

   logic signed [A_BITS-1:0]           a_sum;
   logic signed [B_BITS-1:0]           b_sum;

   always_comb begin
      a_sum = A_BITS'(pa2_ff[0]) + A_BITS'(pa2_ff[1]) + A_BITS'(pa2_ff[2]);
      b_sum = B_BITS'(pb2_ff[0]) + B_BITS'(pb2_ff[1]) + B_BITS'(pb2_ff[2]);
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         c1_ff   <= carry_in;
         nrm1_ff <= nrm_ff;
         for (int i = 0; i < 3; i++) begin
            diff1_ff[i] <= DIFF_BITS'($signed(carry_in.cam[i]))
                         - DIFF_BITS'($signed(org_ff[i]));
         end

         c2_ff <= c1_ff;
         for (int i = 0; i < 3; i++) begin
            pa2_ff[i] <= PA_BITS'(diff1_ff[i]) * PA_BITS'($signed(nrm1_ff[i]));
            pb2_ff[i] <= PB_BITS'($signed(c1_ff.ray[i])) * PB_BITS'($signed(nrm1_ff[i]));
         end

         c3_ff <= c2_ff;
         a3_ff <= a_sum;
         b3_ff <= b_sum;

         c4_ff   <= c3_ff;
         am4_ff  <= a3_ff[A_BITS-1] ? AM_BITS'(-a3_ff) : AM_BITS'(a3_ff);
         bm4_ff  <= b3_ff[B_BITS-1] ? BM_BITS'(-b3_ff) : BM_BITS'(b3_ff);
         par4_ff <= (b3_ff == '0);
         for (int i = 0; i < 3; i++) begin
            rabs4_ff[i] <= c3_ff.ray[i][WORD_BITS-1] ? -c3_ff.ray[i] : c3_ff.ray[i];
         end

         // |a| is split so each multiplier stays about one word wide
         c5_ff   <= c4_ff;
         bm5_ff  <= bm4_ff;
         par5_ff <= par4_ff;
         for (int i = 0; i < 3; i++) begin
            pplo5_ff[i] <= (2*WORD_BITS)'(am4_ff[WORD_BITS-1:0]) * (2*WORD_BITS)'(rabs4_ff[i]);
            pphi5_ff[i] <= (AH_BITS+WORD_BITS)'(am4_ff[AM_BITS-1:WORD_BITS])
                         * (AH_BITS+WORD_BITS)'(rabs4_ff[i]);
         end

         c6_ff   <= c5_ff;
         bm6_ff  <= bm5_ff;
         par6_ff <= par5_ff;
         for (int i = 0; i < 3; i++) begin
            n6_ff[i] <= {pphi5_ff[i], {WORD_BITS{1'b0}}} + N_BITS'(pplo5_ff[i]);
         end
      end
   end

   // s7: divider setup; a quotient of 2^(WORD_BITS+1) or more clamps anyway,
   // so only the low quotient bits are worked out and the rest is a compare
   div_side_type                    side_s [Q_BITS+1];
   logic                            vld_s  [Q_BITS+1];
   logic [2:0][BM_BITS-1:0]         rem_s  [Q_BITS+1];
   logic [2:0][Q_BITS-1:0]          low_s  [Q_BITS+1];
   logic [2:0][Q_BITS-1:0]          q_s    [Q_BITS+1];

   logic [H_BITS-1:0] head;
   logic [2:0]        ovf_in;
   logic [2:0][BM_BITS-1:0] rem0_in;

   div_side_type             side0_ff;
   logic [2:0][BM_BITS-1:0]  rem0_ff;
   logic [2:0][Q_BITS-1:0]   low0_ff;

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         head       = n6_ff[i][N_BITS-1:Q_BITS];
         ovf_in[i]  = (head >= H_BITS'(bm6_ff));
         rem0_in[i] = ovf_in[i] ? '0 : BM_BITS'(head);
      end
   end

   assign vld_s[0]  = vld_ff[6];
   assign side_s[0] = side0_ff;
   assign rem_s[0]  = rem0_ff;
   assign low_s[0]  = low0_ff;
   assign q_s[0]    = '0;

   always_ff @(posedge clock) begin
      if (adv) begin
         side0_ff.carry    <= c6_ff;
         side0_ff.parallel <= par6_ff;
         side0_ff.ovf      <= ovf_in;
         side0_ff.div      <= bm6_ff;
         rem0_ff           <= rem0_in;
         for (int i = 0; i < 3; i++) begin
            low0_ff[i] <= n6_ff[i][Q_BITS-1:0];
         end
      end
   end

   for (genvar k = 0; k < Q_BITS; k++) begin : g_div
      rpi_div_stage u_step (
         .clock  (clock),
         .en     (adv),
         .vld_i  (vld_s[k]),
         .side_i (side_s[k]),
         .rem_i  (rem_s[k]),
         .low_i  (low_s[k]),
         .q_i    (q_s[k]),
         .reset  (reset),
         .vld_o  (vld_s[k+1]),
         .side_o (side_s[k+1]),
         .rem_o  (rem_s[k+1]),
         .low_o  (low_s[k+1]),
         .q_o    (q_s[k+1])
      );
   end

   // output stage: clamp camera + signed offset; ortho clamps ray + camera instead, parallel passes the camera
   div_side_type fin;
   rsp_type      rsp_in;
   logic [Q_BITS-1:0]         mag;
   logic signed [SUM_BITS-1:0] off;
   logic [2:0][WORD_BITS-1:0] hit;

   assign fin = side_s[Q_BITS];

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         mag    = fin.ovf[i] ? {Q_BITS{1'b1}} : q_s[Q_BITS][i];
         off    = fin.carry.ray[i][WORD_BITS-1] ? -SUM_BITS'(mag) : SUM_BITS'(mag);
         hit[i] = sat_word(SUM_BITS'($signed(fin.carry.cam[i])) + off);
      end
      if (fin.carry.ortho) begin
         rsp_in.hit_x    = '0;
         rsp_in.hit_y    = sat_word(SUM_BITS'($signed(fin.carry.ray[0]))
                                  + SUM_BITS'($signed(fin.carry.cam[1])));
         rsp_in.hit_z    = sat_word(SUM_BITS'($signed(fin.carry.ray[1]))
                                  + SUM_BITS'($signed(fin.carry.cam[2])));
         rsp_in.parallel = 1'b0;
      end else if (fin.parallel) begin
         rsp_in.hit_x    = fin.carry.cam[0];
         rsp_in.hit_y    = fin.carry.cam[1];
         rsp_in.hit_z    = fin.carry.cam[2];
         rsp_in.parallel = 1'b1;
      end else begin
         rsp_in.hit_x    = hit[0];
         rsp_in.hit_y    = hit[1];
         rsp_in.hit_z    = hit[2];
         rsp_in.parallel = 1'b0;
      end
   end

   rsp_type rsp_data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (adv) begin
         rsp_valid_ff <= vld_s[Q_BITS];
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         rsp_data_ff <= rsp_in;
      end
   end

   assign rsp_data = rsp_data_ff;

endmodule

### rtl/rpi_div_stage.sv
module rpi_div_stage (
   input  logic                                clock,
   input  logic                                en,
   input  logic                                vld_i,
   input  rpi_pkg::div_side_type               side_i,
   input  logic [2:0][rpi_pkg::BM_BITS-1:0]    rem_i,
   input  logic [2:0][rpi_pkg::Q_BITS-1:0]     low_i,
   input  logic [2:0][rpi_pkg::Q_BITS-1:0]     q_i,
   input  logic                                reset,
   output logic                                vld_o,
   output rpi_pkg::div_side_type               side_o,
   output logic [2:0][rpi_pkg::BM_BITS-1:0]    rem_o,
   output logic [2:0][rpi_pkg::Q_BITS-1:0]     low_o,
   output logic [2:0][rpi_pkg::Q_BITS-1:0]     q_o
);
   import rpi_pkg::*;

   logic [2:0][BM_BITS-1:0] rem_in;
   logic [2:0][Q_BITS-1:0]  low_in;
   logic [2:0][Q_BITS-1:0]  q_in;
   logic [BM_BITS:0]        trial;
   logic                    ge;

   // one restoring step per lane: bring down the next numerator bit
   always_comb begin
      for (int i = 0; i < 3; i++) begin
         trial     = {rem_i[i], low_i[i][Q_BITS-1]};
         ge        = (trial >= {1'b0, side_i.div});
         rem_in[i] = ge ? BM_BITS'(trial - {1'b0, side_i.div}) : trial[BM_BITS-1:0];
         low_in[i] = {low_i[i][Q_BITS-2:0], 1'b0};
         q_in[i]   = {q_i[i][Q_BITS-2:0], ge};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_o <= 1'b0;
      end else if (en) begin
         vld_o <= vld_i;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         side_o <= side_i;
         rem_o  <= rem_in;
         low_o  <= low_in;
         q_o    <= q_in;
      end
   end

endmodule
